// ===== design/clps_pkg.sv =====
// Shared types and constants for the charlieplex LED scanner.
// Holds field widths, operation and register codes, and the pixel write word.
// No dependencies.
`default_nettype none

package clps_pkg;

	localparam int MODE_W    = 2;
	localparam int INDEX_W   = 8;
	localparam int PIN_W     = 16;
	localparam int ROW_OUT_W = 4;
	localparam int TIME_W    = 15;
	localparam int COUNT_W   = 16;
	localparam int PIX_IDX_W = 4;
	localparam int CFG_IDX_W = 1;

	localparam int PIN_COUNT_DEF = 16;

	localparam logic [TIME_W-1:0] ON_TIME_RST  = 15'd100;
	localparam logic [TIME_W-1:0] OFF_TIME_RST = 15'd10;

	typedef enum logic [MODE_W-1:0] {
		MODE_SET_PIXEL = 2'd0,
		MODE_START     = 2'd1,
		MODE_TICK      = 2'd2,
		MODE_NONE      = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ON_TIME  = 1'b0,
		CFG_OFF_TIME = 1'b1
	} cfg_idx_t;

	// one pixel write: wr marks an in-range index
	typedef struct packed {
		logic                 wr;
		logic [PIX_IDX_W-1:0] row;
		logic [PIX_IDX_W-1:0] col;
		logic                 lit;
	} clps_pix_t;

endpackage

`default_nettype wire

// ===== design/clps_if.sv =====
// Valid/ready channel interfaces for the scanner's input and result words.
// Depends on clps_pkg for field widths.
`default_nettype none

interface clps_in_if import clps_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [INDEX_W-1:0] pixel_index;
	logic               lit;

	modport source(output valid, output mode, output pixel_index, output lit, input ready);
	modport sink(input valid, input mode, input pixel_index, input lit, output ready);
endinterface

interface clps_out_if import clps_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PIN_W-1:0]     pin_enable;
	logic [PIN_W-1:0]     pin_level;
	logic                 scanning;
	logic [ROW_OUT_W-1:0] next_row;

	modport source(output valid, output pin_enable, output pin_level, output scanning,
		output next_row, input ready);
	modport sink(input valid, input pin_enable, input pin_level, input scanning,
		input next_row, output ready);
endinterface

`default_nettype wire

// ===== design/clps_decode.sv =====
// Splits an LED number into driving row and column, skipping the diagonal.
// Depends on clps_pkg. Pure combinational: compares against constant row bases.
`default_nettype none

module clps_decode import clps_pkg::*; #(
	parameter int PIN_COUNT = PIN_COUNT_DEF
) (
	input  wire logic [INDEX_W-1:0] pixel_index,
	input  wire logic               lit,
	output clps_pix_t               pix
);

	localparam int DIVISOR = PIN_COUNT - 1;
	localparam int LIMIT   = PIN_COUNT * DIVISOR;

	logic [PIX_IDX_W-1:0] row;
	logic [INDEX_W-1:0]   base;
	logic [INDEX_W-1:0]   rem;

	// row = number of row bases at or below the index
	always_comb begin
		row = '0;
		for (int k = 1; k < PIN_COUNT; k++) begin
			if ({1'b0, pixel_index} >= (INDEX_W+1)'(k * DIVISOR))
				row = PIX_IDX_W'(k);
		end
		base = INDEX_W'(int'(row) * DIVISOR);
		rem  = pixel_index - base;
	end

	always_comb begin
		pix.wr  = ({1'b0, pixel_index} < (INDEX_W+1)'(LIMIT));
		pix.row = row;
		// step over the row's own pin
		pix.col = rem[PIX_IDX_W-1:0] +
			PIX_IDX_W'(rem >= {{(INDEX_W-PIX_IDX_W){1'b0}}, row});
		pix.lit = lit;
	end

endmodule

`default_nettype wire

// ===== design/clps_row_table.sv =====
// Lit-column table: one bit per LED, one row per driving pin.
// Depends on clps_pkg. Single bit write port, one combinational row read.
`default_nettype none

module clps_row_table import clps_pkg::*; #(
	parameter int PIN_COUNT = PIN_COUNT_DEF,
	localparam int ROW_W = $clog2(PIN_COUNT)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire clps_pix_t            wr,
	input  wire logic [ROW_W-1:0]     rd_row,
	output logic      [PIN_COUNT-1:0] rd_data
);

	logic [PIN_COUNT-1:0] lit_q [PIN_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIN_COUNT; i++)
				lit_q[i] <= '0;
		end else if (wr.wr) begin
			lit_q[wr.row[ROW_W-1:0]][wr.col[ROW_W-1:0]] <= wr.lit;
		end
	end

	assign rd_data = lit_q[rd_row];

endmodule

`default_nettype wire

// ===== design/charlieplex_led_scanner_unit.sv =====
// Charlieplex LED scanner: one input word in, one result word out per accept.
// The input word is held in the input register, then the result in the result register.
// Throughput: one word per cycle while the result channel is not stalled.
// Reset clears the row table, counter, row pointer and scan flag, all pins to
// high impedance, and loads on_time = 100, off_time = 10.
`default_nettype none

module charlieplex_led_scanner_unit import clps_pkg::*; #(
	parameter int PIN_COUNT = PIN_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	clps_in_if.sink                   in_ch,
	clps_out_if.source                out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TIME_W-1:0]    cfg_data
);

	localparam int ROW_W = $clog2(PIN_COUNT);

	// input stage
	logic      valid_s1;
	mode_t     mode_s1;
	clps_pix_t pix_s1;
	clps_pix_t pix_dec;
	clps_pix_t pix_wr;

	// scan state
	logic [TIME_W-1:0]    on_q, off_q;
	logic [COUNT_W-1:0]   tick_q, tick_d;
	logic [ROW_W-1:0]     row_q, row_d;
	logic                 run_q, run_d;
	logic [PIN_COUNT-1:0] en_q, en_d;
	logic [PIN_COUNT-1:0] lvl_q, lvl_d;
	logic [PIN_COUNT-1:0] row_lit;

	// tick arithmetic
	logic [COUNT_W-1:0]   period;
	logic [COUNT_W:0]     tick_inc;
	logic                 wrap;
	logic [COUNT_W-1:0]   tick_next;
	logic                 load;
	logic [PIN_COUNT-1:0] row_pin;
	logic [ROW_W-1:0]     row_adv;

	// result register
	logic                 out_valid_q;
	logic [PIN_W-1:0]     out_en_q, out_lvl_q;
	logic                 out_run_q;
	logic [ROW_OUT_W-1:0] out_row_q;

	logic advance;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	clps_decode #(.PIN_COUNT(PIN_COUNT)) u_decode (
		.pixel_index (in_ch.pixel_index),
		.lit         (in_ch.lit),
		.pix         (pix_dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			mode_s1 <= mode_t'(in_ch.mode);
			pix_s1  <= pix_dec;
		end
	end

	always_comb begin
		pix_wr    = pix_s1;
		pix_wr.wr = pix_s1.wr && advance && (mode_s1 == MODE_SET_PIXEL);
	end

	clps_row_table #(.PIN_COUNT(PIN_COUNT)) u_row_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (pix_wr),
		.rd_row  (row_q),
		.rd_data (row_lit)
	);

	always_comb begin
		period    = COUNT_W'({1'b0, on_q}) + COUNT_W'({1'b0, off_q});
		tick_inc  = {1'b0, tick_q} + (COUNT_W+1)'(1);
		wrap      = (tick_inc >= {1'b0, period});
		tick_next = wrap ? '0 : tick_inc[COUNT_W-1:0];
		load      = (tick_next == COUNT_W'({1'b0, off_q}));
		row_pin   = PIN_COUNT'(1) << row_q;
		row_adv   = (row_q == ROW_W'(PIN_COUNT - 1)) ? '0 : row_q + ROW_W'(1);
	end

	always_comb begin
		tick_d = tick_q;
		row_d  = row_q;
		run_d  = run_q;
		en_d   = en_q;
		lvl_d  = lvl_q;
		unique case (mode_s1)
			MODE_START: begin
				if (!run_q) begin
					tick_d = '0;
					row_d  = '0;
					run_d  = 1'b1;
				end
			end
			MODE_TICK: begin
				if (run_q) begin
					tick_d = tick_next;
					if (wrap)
						lvl_d = '0;
					// load wins over the wrap's clear
					if (load) begin
						en_d  = row_lit | row_pin;
						lvl_d = row_pin;
						row_d = row_adv;
					end
				end
			end
			MODE_SET_PIXEL, MODE_NONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			row_q  <= '0;
			run_q  <= 1'b0;
			en_q   <= '0;
			lvl_q  <= '0;
		end else if (advance) begin
			tick_q <= tick_d;
			row_q  <= row_d;
			run_q  <= run_d;
			en_q   <= en_d;
			lvl_q  <= lvl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q  <= ON_TIME_RST;
			off_q <= OFF_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ON_TIME:  on_q  <= cfg_data;
				CFG_OFF_TIME: off_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_en_q  <= PIN_W'(en_d);
			out_lvl_q <= PIN_W'(lvl_d);
			out_run_q <= run_d;
			out_row_q <= ROW_OUT_W'(row_d);
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.pin_enable = out_en_q;
	assign out_ch.pin_level  = out_lvl_q;
	assign out_ch.scanning   = out_run_q;
	assign out_ch.next_row   = out_row_q;

`ifndef SYNTH
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_W'(PIN_COUNT - 1))
		else $error("row pointer past last pin");

	a_level_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(lvl_q))
		else $error("more than one pin driven high");

	a_level_driven: assert property (@(posedge clk) disable iff (!arst_n)
		(lvl_q & ~en_q) == '0)
		else $error("high level on an undriven pin");

	a_run_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |=> run_q)
		else $error("scan flag dropped");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> valid_s1 && out_valid_q && !out_ch.ready)
		else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_charlieplex_led_scanner_unit.sv =====
// Self-checking testbench for charlieplex_led_scanner_unit: drives pixel, start, tick
// and no-op words with random idling on both channels and checks every result word.
// Depends on clps_pkg, clps_in_if, clps_out_if and the scanner RTL.
`default_nettype none

module tb_charlieplex_led_scanner_unit;
	import clps_pkg::*;

	localparam int PINS        = PIN_COUNT_DEF;
	localparam int LED_COUNT   = PINS * (PINS - 1);
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [PIN_W-1:0]     pin_enable;
		logic [PIN_W-1:0]     pin_level;
		logic                 scanning;
		logic [ROW_OUT_W-1:0] next_row;
	} pin_view_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TIME_W-1:0] cfg_data;

	clps_in_if  in_ch();
	clps_out_if out_ch();

	charlieplex_led_scanner_unit #(.PIN_COUNT(PINS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// scanner state as predicted from the words accepted so far
	logic [PIN_W-1:0]     row_leds [PINS];
	logic [COUNT_W-1:0]   period_count;
	logic [ROW_OUT_W-1:0] load_row;
	logic                 running;
	logic [PIN_W-1:0]     drive_mask;
	logic [PIN_W-1:0]     high_mask;
	logic [TIME_W-1:0]    on_ticks;
	logic [TIME_W-1:0]    off_ticks;

	pin_view_t pin_views_q[$];

	bit quiet;
	int mismatches;
	int idle_cycles;
	int words_sent;
	int pixel_writes;
	int tick_words;
	int row_loads;
	int wraps;
	int settings_used;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void predict_word(mode_t m, logic [INDEX_W-1:0] idx, logic lt);
		int row;
		int col;
		logic [16:0] nxt;
		logic [16:0] period;
		pin_view_t v;
		case (m)
			MODE_SET_PIXEL: begin
				if (idx < LED_COUNT) begin
					row = idx / (PINS - 1);
					col = idx % (PINS - 1);
					if (col >= row)
						col++;
					row_leds[row][col] = lt;
					pixel_writes++;
				end
			end
			MODE_START: begin
				if (!running) begin
					period_count = '0;
					load_row = '0;
					running = 1'b1;
				end
			end
			MODE_TICK: begin
				if (running) begin
					tick_words++;
					period = {2'b0, on_ticks} + {2'b0, off_ticks};
					nxt = {1'b0, period_count} + 17'd1;
					if (nxt >= period) begin
						nxt = '0;
						high_mask = '0;
						wraps++;
					end
					period_count = nxt[COUNT_W-1:0];
					if (nxt == {2'b0, off_ticks}) begin
						drive_mask = row_leds[load_row] | (PIN_W'(1) << load_row);
						high_mask = PIN_W'(1) << load_row;
						load_row = (load_row == PINS - 1) ? '0 : load_row + 1'b1;
						row_loads++;
					end
				end
			end
			default: ;
		endcase
		v.pin_enable = drive_mask;
		v.pin_level = high_mask;
		v.scanning = running;
		v.next_row = load_row;
		pin_views_q.push_back(v);
	endfunction

	// hold valid high across back-to-back words; drop it only for a gap
	task automatic send_word(mode_t m, logic [INDEX_W-1:0] idx, logic lt);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= m;
		in_ch.pixel_index <= idx;
		in_ch.lit <= lt;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_word(m, idx, lt);
		words_sent++;
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pin_views_q.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t r, logic [TIME_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		@(posedge clk);
		if (r == CFG_ON_TIME)
			on_ticks = d;
		else
			off_ticks = d;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timing(logic [TIME_W-1:0] on_val, logic [TIME_W-1:0] off_val);
		wait_drained();
		write_reg(CFG_ON_TIME, on_val);
		write_reg(CFG_OFF_TIME, off_val);
		settings_used++;
	endtask

	task automatic test_idle_words();
		send_word(MODE_NONE, 8'hFF, 1'b1);
		send_word(MODE_TICK, 8'h00, 1'b0);
	endtask

	task automatic test_pixel_map();
		send_word(MODE_SET_PIXEL, 8'd0, 1'b1);
		send_word(MODE_SET_PIXEL, 8'd14, 1'b1);
		send_word(MODE_SET_PIXEL, 8'd15, 1'b1);
		send_word(MODE_SET_PIXEL, 8'd16, 1'b1);
		send_word(MODE_SET_PIXEL, 8'd239, 1'b1);
		send_word(MODE_SET_PIXEL, 8'd240, 1'b1);
		send_word(MODE_SET_PIXEL, 8'd255, 1'b1);
		send_word(MODE_SET_PIXEL, 8'd0, 1'b0);
	endtask

	// zero off time: wrap and row load land on the same tick
	task automatic test_start_scan();
		set_timing(15'd1, 15'd0);
		send_word(MODE_START, 8'h00, 1'b0);
		send_word(MODE_START, 8'hAA, 1'b1);
		repeat (5) send_word(MODE_TICK, 8'h55, 1'b0);
		set_timing(15'd2, 15'd1);
		repeat (4) send_word(MODE_TICK, 8'h00, 1'b0);
	endtask

	task automatic test_random_scan(int n_words);
		int sel;
		logic [INDEX_W-1:0] idx;
		repeat (n_words) begin
			sel = $urandom_range(0, 99);
			idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(LED_COUNT, 255))
				: 8'($urandom_range(0, LED_COUNT - 1));
			if (sel < 35)
				send_word(MODE_SET_PIXEL, idx, $urandom_range(0, 9) < 7);
			else if (sel < 90)
				send_word(MODE_TICK, 8'($urandom), 1'($urandom));
			else if (sel < 95)
				send_word(MODE_START, 8'($urandom), 1'($urandom));
			else
				send_word(MODE_NONE, 8'($urandom), 1'($urandom));
		end
	endtask

	// result checker
	always @(posedge clk) begin
		pin_view_t got;
		pin_view_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.pin_enable = out_ch.pin_enable;
			got.pin_level = out_ch.pin_level;
			got.scanning = out_ch.scanning;
			got.next_row = out_ch.next_row;
			if (pin_views_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: unexpected result word en=%h lvl=%h scan=%b row=%0d",
						got.pin_enable, got.pin_level, got.scanning, got.next_row);
			end else begin
				want = pin_views_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("ERROR: exp en=%h lvl=%h scan=%b row=%0d,",
							want.pin_enable, want.pin_level, want.scanning,
							want.next_row);
						$display("       got en=%h lvl=%h scan=%b row=%0d",
							got.pin_enable, got.pin_level, got.scanning,
							got.next_row);
					end
				end
			end
		end
	end

	// result backpressure in random bursts
	initial begin
		int stall_left;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 16);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		quiet = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ON_TIME;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.mode <= MODE_NONE;
		in_ch.pixel_index <= '0;
		in_ch.lit <= 1'b0;
		foreach (row_leds[i])
			row_leds[i] = '0;
		period_count = '0;
		load_row = '0;
		running = 1'b0;
		drive_mask = '0;
		high_mask = '0;
		on_ticks = ON_TIME_RST;
		off_ticks = OFF_TIME_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_words();
		test_pixel_map();
		test_start_scan();

		// grow, then shrink below the running count, then the extremes
		set_timing(15'd3, 15'd2);
		test_random_scan(170);
		set_timing(15'd40, 15'd30);
		test_random_scan(170);
		set_timing(15'd2, 15'd1);
		test_random_scan(170);
		set_timing(15'h7FFF, 15'h7FFF);
		test_random_scan(150);
		set_timing(15'd0, 15'd0);
		test_random_scan(170);
		set_timing(15'd1, 15'd0);
		test_random_scan(170);
		set_timing(15'($urandom_range(1, 12)), 15'($urandom_range(1, 12)));
		test_random_scan(170);
		set_timing(ON_TIME_RST, OFF_TIME_RST);
		test_random_scan(170);
		set_timing(15'($urandom_range(1, 6)), 15'($urandom_range(0, 6)));
		quiet = 1'b1;
		test_random_scan(170);

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Covered %0d words: %0d pixel writes, %0d running ticks, %0d wraps,",
			words_sent, pixel_writes, tick_words, wraps);
		$display("%0d row loads across %0d timing settings; %0d mismatches.",
			row_loads, settings_used, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
design/clps_pkg.sv
design/clps_if.sv
design/clps_decode.sv
design/clps_row_table.sv
design/charlieplex_led_scanner_unit.sv
verif/tb_charlieplex_led_scanner_unit.sv
